// ----- sv/dbtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtd_pkg
// Shared types, constants and the control store of the dual band tone
// detector.
// ----------------------------------------------------------------------------
package dbtd_pkg;

    // sample and coefficient formats
    localparam int SAMPLE_BITS    = 12;
    localparam int COEF_FRAC_BITS = 14;
    localparam int X_W            = SAMPLE_BITS + 1;
    localparam int DIFF_W         = SAMPLE_BITS + 2;
    localparam int MIDSCALE       = 1 << (SAMPLE_BITS - 1);

    localparam int COEF_W = 16;
    localparam int Y_W    = 16;
    localparam int PWR_W  = 30;

    // shared multiplier and accumulator
    localparam int OPA_W  = 17;
    localparam int OPB_W  = 32;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W;

    localparam logic signed [ACC_W-1:0] FLT_HALF = ACC_W'(1 << (COEF_FRAC_BITS - 1));
    localparam logic signed [ACC_W-1:0] Y_MAX    = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] Y_MIN    = ACC_W'(-32768);

    // power smoothing, Q0.16 weights
    localparam int PWR_FRAC = 16;
    localparam logic [OPA_W-1:0] DECAY_WEIGHT = OPA_W'(65470);
    localparam logic [OPA_W-1:0] GAIN_WEIGHT  = OPA_W'(66);
    localparam logic [ACC_W-1:0] PWR_HALF     = ACC_W'(32768);
    localparam logic [PWR_W-1:0] PWR_MAX      = '1;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_B0   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_A1   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TONE_A2   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REF_B0    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_A1    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REF_A2    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 3'd6;

    // configuration reset values
    localparam logic [COEF_W-1:0] RST_TONE_B0   = 16'(383);
    localparam logic [COEF_W-1:0] RST_TONE_A1   = 16'(-25228);
    localparam logic [COEF_W-1:0] RST_TONE_A2   = 16'(15618);
    localparam logic [COEF_W-1:0] RST_REF_B0    = 16'(1010);
    localparam logic [COEF_W-1:0] RST_REF_A1    = 16'(-24240);
    localparam logic [COEF_W-1:0] RST_REF_A2    = 16'(14365);
    localparam logic [COEF_W-1:0] RST_THRESHOLD = 16'(36045);

    // command codes
    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_REPORT = 1'b1;

    // operand a select
    localparam logic [3:0] A_TONE_B0 = 4'd0;
    localparam logic [3:0] A_TONE_A1 = 4'd1;
    localparam logic [3:0] A_TONE_A2 = 4'd2;
    localparam logic [3:0] A_REF_B0  = 4'd3;
    localparam logic [3:0] A_REF_A1  = 4'd4;
    localparam logic [3:0] A_REF_A2  = 4'd5;
    localparam logic [3:0] A_THRESH  = 4'd6;
    localparam logic [3:0] A_DECAY   = 4'd7;
    localparam logic [3:0] A_GAIN    = 4'd8;
    localparam logic [3:0] A_TONE_Y  = 4'd9;
    localparam logic [3:0] A_REF_Y   = 4'd10;

    // operand b select
    localparam logic [2:0] B_DIFF    = 3'd0;
    localparam logic [2:0] B_TONE_Y1 = 3'd1;
    localparam logic [2:0] B_TONE_Y2 = 3'd2;
    localparam logic [2:0] B_REF_Y1  = 3'd3;
    localparam logic [2:0] B_REF_Y2  = 3'd4;
    localparam logic [2:0] B_TONE_P  = 3'd5;
    localparam logic [2:0] B_REF_P   = 3'd6;
    localparam logic [2:0] B_PROD    = 3'd7;

    // accumulator operations on the registered product
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_LOAD = 2'd1;
    localparam logic [1:0] ACC_ADD  = 2'd2;
    localparam logic [1:0] ACC_SUB  = 2'd3;

    // write-back targets
    localparam logic [2:0] DST_NONE   = 3'd0;
    localparam logic [2:0] DST_TONE_Y = 3'd1;
    localparam logic [2:0] DST_REF_Y  = 3'd2;
    localparam logic [2:0] DST_TONE_P = 3'd3;
    localparam logic [2:0] DST_REF_P  = 3'd4;
    localparam logic [2:0] DST_FLAG   = 3'd5;
    localparam logic [2:0] DST_CLEAR  = 3'd6;

    // program counter
    localparam int PC_W = 5;
    localparam logic [PC_W-1:0] PC_START  = 5'd0;
    localparam logic [PC_W-1:0] PC_REPORT = 5'd17;

    typedef struct packed {
        logic [3:0] a_sel;
        logic [2:0] b_sel;
        logic [1:0] acc_op;
        logic [2:0] dest;
        logic       jump_report;
        logic       last;
    } ucode_t;

    typedef struct packed {
        logic            run;
        logic            step_en;
        logic [PC_W-1:0] pc;
        ucode_t          word;
    } ctrl_t;

    typedef struct packed {
        logic [COEF_W-1:0] tone_b0;
        logic [COEF_W-1:0] tone_a1;
        logic [COEF_W-1:0] tone_a2;
        logic [COEF_W-1:0] ref_b0;
        logic [COEF_W-1:0] ref_a1;
        logic [COEF_W-1:0] ref_a2;
        logic [COEF_W-1:0] threshold_ratio;
    } coef_t;

    // control store: product of step n is accumulated in step n+1
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{a_sel: A_GAIN, b_sel: B_PROD, acc_op: ACC_HOLD, dest: DST_NONE,
              jump_report: 1'b0, last: 1'b0};
        case (pc)
            5'd0:
            begin
                w.a_sel = A_TONE_B0; w.b_sel = B_DIFF; w.jump_report = 1'b1;
            end
            5'd1:
            begin
                w.a_sel = A_TONE_A1; w.b_sel = B_TONE_Y1; w.acc_op = ACC_LOAD;
            end
            5'd2:
            begin
                w.a_sel = A_TONE_A2; w.b_sel = B_TONE_Y2; w.acc_op = ACC_SUB;
            end
            5'd3:
            begin
                w.a_sel = A_REF_B0; w.b_sel = B_DIFF; w.acc_op = ACC_SUB;
            end
            5'd4:
            begin
                w.a_sel = A_REF_A1; w.b_sel = B_REF_Y1; w.acc_op = ACC_LOAD;
                w.dest = DST_TONE_Y;
            end
            5'd5:
            begin
                w.a_sel = A_REF_A2; w.b_sel = B_REF_Y2; w.acc_op = ACC_SUB;
            end
            5'd6:
            begin
                w.a_sel = A_TONE_Y; w.b_sel = B_TONE_Y1; w.acc_op = ACC_SUB;
            end
            5'd7:
            begin
                w.a_sel = A_GAIN; w.b_sel = B_PROD; w.dest = DST_REF_Y;
            end
            5'd8:
            begin
                w.a_sel = A_DECAY; w.b_sel = B_TONE_P; w.acc_op = ACC_LOAD;
            end
            5'd9:
            begin
                w.a_sel = A_REF_Y; w.b_sel = B_REF_Y1; w.acc_op = ACC_ADD;
            end
            5'd10:
            begin
                w.a_sel = A_GAIN; w.b_sel = B_PROD; w.dest = DST_TONE_P;
            end
            5'd11:
            begin
                w.a_sel = A_DECAY; w.b_sel = B_REF_P; w.acc_op = ACC_LOAD;
            end
            5'd12:
            begin
                w.acc_op = ACC_ADD;
            end
            5'd13:
            begin
                w.dest = DST_REF_P;
            end
            5'd14:
            begin
                w.a_sel = A_THRESH; w.b_sel = B_REF_P;
            end
            5'd15:
            begin
                w.dest = DST_FLAG;
            end
            5'd16:
            begin
                w.last = 1'b1;
            end
            5'd17:
            begin
                w.dest = DST_CLEAR; w.last = 1'b1;
            end
            default:
            begin
                w.last = 1'b1;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- sv/dual_band_tone_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_band_tone_detector
// Two biquad bandpass filters with smoothed band powers and a sticky tone
// detection flag, run by a microcoded sequencer around one multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries command and sample. A sample
//   command runs both filters, updates both powers and the flag; a report
//   command returns the flag and powers and then clears the flag.
//   Every input beat produces exactly one output beat on out_valid /
//   out_stall, carrying detected, tone_power and reference_power.
//   The cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   coefficient registers; cfg_ready is always high, unknown indexes are
//   dropped. Write only while no beat is in flight.
// Timing:
//   A sample beat runs every step of the shared multiplier program, a report
//   beat only the first step and then the flag clear step; the result is
//   written to the output register at the end of the last program step, and
//   the next input beat is taken on that same edge.
// Reset and stall:
//   Reset clears filter history, powers, flag and the default coefficients
//   are loaded. While out_stall holds a result, the next beat may still be
//   taken and run; it waits on its last step until the output register frees.
// ----------------------------------------------------------------------------
module dual_band_tone_detector
(
    input  logic                                clk,
    input  logic                                rst_n,
    // input beat
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                command,
    input  logic [dbtd_pkg::SAMPLE_BITS-1:0]    sample,
    // output beat
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                detected,
    output logic [dbtd_pkg::PWR_W-1:0]          tone_power,
    output logic [dbtd_pkg::PWR_W-1:0]          reference_power,
    // configuration writes
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [dbtd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dbtd_pkg::COEF_W-1:0]         cfg_data
);

    dbtd_pkg::coef_t             coef;
    dbtd_pkg::ctrl_t             ctrl;
    logic                        done;
    logic                        accept;
    logic                        emit_block;
    logic                        flag;
    logic [dbtd_pkg::PWR_W-1:0]  tone_energy;
    logic [dbtd_pkg::PWR_W-1:0]  ref_energy;

    logic                        out_valid_reg, out_valid_next;
    logic                        detected_reg;
    logic [dbtd_pkg::PWR_W-1:0]  tone_power_reg, ref_power_reg;

    // handshakes
    assign cfg_ready  = 1'b1;
    assign emit_block = out_valid_reg && out_stall;
    assign in_stall   = ctrl.run && !done;
    assign accept     = in_valid && !in_stall;

    dbtd_regs u_regs
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coef      (coef)
    );

    dbtd_useq u_useq
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (accept),
        .command    (command),
        .emit_block (emit_block),
        .ctrl       (ctrl),
        .done       (done)
    );

    dbtd_datapath u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctrl        (ctrl),
        .coef        (coef),
        .load_sample (accept && (command == dbtd_pkg::CMD_SAMPLE)),
        .sample      (sample),
        .flag        (flag),
        .tone_energy (tone_energy),
        .ref_energy  (ref_energy)
    );

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            detected_reg   <= flag;
            tone_power_reg <= tone_energy;
            ref_power_reg  <= ref_energy;
        end
    end

    assign out_valid       = out_valid_reg;
    assign detected        = detected_reg;
    assign tone_power      = tone_power_reg;
    assign reference_power = ref_power_reg;

`ifndef SYNTHESIS
    // a result is never written over one that is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(out_valid_reg && out_stall))
        else $error("result written while output held");

    // a new output beat only follows the end of a program run
    a_emit_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(done))
        else $error("output valid without program end");

    // an accepted beat starts the program at its first step
    a_start_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (ctrl.run && (ctrl.pc == dbtd_pkg::PC_START)))
        else $error("program did not start on accept");
`endif

endmodule

// ----- sv/dbtd_regs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtd_regs
// Configuration register file: filter coefficients and detection ratio.
// ----------------------------------------------------------------------------
module dbtd_regs
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [dbtd_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [dbtd_pkg::COEF_W-1:0]        cfg_data,
    output dbtd_pkg::coef_t                    coef
);

    dbtd_pkg::coef_t coef_reg;
    dbtd_pkg::coef_t coef_next;

    // decode the register index, unknown indexes are dropped
    always_comb
    begin
        coef_next = coef_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                dbtd_pkg::REG_TONE_B0:   coef_next.tone_b0         = cfg_data;
                dbtd_pkg::REG_TONE_A1:   coef_next.tone_a1         = cfg_data;
                dbtd_pkg::REG_TONE_A2:   coef_next.tone_a2         = cfg_data;
                dbtd_pkg::REG_REF_B0:    coef_next.ref_b0          = cfg_data;
                dbtd_pkg::REG_REF_A1:    coef_next.ref_a1          = cfg_data;
                dbtd_pkg::REG_REF_A2:    coef_next.ref_a2          = cfg_data;
                dbtd_pkg::REG_THRESHOLD: coef_next.threshold_ratio = cfg_data;
                default:                 coef_next                 = coef_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.tone_b0         <= dbtd_pkg::RST_TONE_B0;
            coef_reg.tone_a1         <= dbtd_pkg::RST_TONE_A1;
            coef_reg.tone_a2         <= dbtd_pkg::RST_TONE_A2;
            coef_reg.ref_b0          <= dbtd_pkg::RST_REF_B0;
            coef_reg.ref_a1          <= dbtd_pkg::RST_REF_A1;
            coef_reg.ref_a2          <= dbtd_pkg::RST_REF_A2;
            coef_reg.threshold_ratio <= dbtd_pkg::RST_THRESHOLD;
        end
        else
        begin
            coef_reg <= coef_next;
        end
    end

    assign coef = coef_reg;

endmodule

// ----- sv/dbtd_useq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtd_useq
// Microcode sequencer: step counter, control store lookup and the report
// branch.
// ----------------------------------------------------------------------------
module dbtd_useq
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic            command,
    input  logic            emit_block,
    output dbtd_pkg::ctrl_t ctrl,
    output logic            done
);

    logic                      run_reg;
    logic                      run_next;
    logic [dbtd_pkg::PC_W-1:0] pc_reg;
    logic [dbtd_pkg::PC_W-1:0] pc_next;
    logic                      cmd_reg;
    logic                      cmd_next;
    dbtd_pkg::ucode_t          word;
    logic                      step_en;

    // control word of the current step
    assign word    = dbtd_pkg::ucode_rom(pc_reg);
    assign step_en = run_reg && !(word.last && emit_block);
    assign done    = step_en && word.last;

    // next step, branch to the report routine on step zero
    always_comb
    begin
        run_next = run_reg;
        pc_next  = pc_reg;
        cmd_next = cmd_reg;
        if (step_en)
        begin
            if (word.last)
            begin
                run_next = 1'b0;
            end
            else if (word.jump_report && (cmd_reg == dbtd_pkg::CMD_REPORT))
            begin
                pc_next = dbtd_pkg::PC_REPORT;
            end
            else
            begin
                pc_next = pc_reg + dbtd_pkg::PC_W'(1);
            end
        end
        if (start)
        begin
            run_next = 1'b1;
            pc_next  = dbtd_pkg::PC_START;
            cmd_next = command;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            pc_reg  <= dbtd_pkg::PC_START;
            cmd_reg <= dbtd_pkg::CMD_SAMPLE;
        end
        else
        begin
            run_reg <= run_next;
            pc_reg  <= pc_next;
            cmd_reg <= cmd_next;
        end
    end

    assign ctrl.run     = run_reg;
    assign ctrl.step_en = step_en;
    assign ctrl.pc      = pc_reg;
    assign ctrl.word    = word;

endmodule

// ----- sv/dbtd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dbtd_datapath
// Shared multiplier, accumulator, filter and power state, detection flag.
// ----------------------------------------------------------------------------
module dbtd_datapath
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  dbtd_pkg::ctrl_t                     ctrl,
    input  dbtd_pkg::coef_t                     coef,
    input  logic                                load_sample,
    input  logic [dbtd_pkg::SAMPLE_BITS-1:0]    sample,
    output logic                                flag,
    output logic [dbtd_pkg::PWR_W-1:0]          tone_energy,
    output logic [dbtd_pkg::PWR_W-1:0]          ref_energy
);

    // input delay line and filter input difference
    logic [dbtd_pkg::X_W-1:0]    xd1_reg, xd2_reg;
    logic [dbtd_pkg::X_W-1:0]    x_val;
    logic [dbtd_pkg::DIFF_W-1:0] diff_reg, diff_next;

    // filter history and smoothed powers
    logic [dbtd_pkg::Y_W-1:0]    ty1_reg, ty2_reg, ry1_reg, ry2_reg;
    logic [dbtd_pkg::PWR_W-1:0]  te_reg, re_reg;
    logic                        flag_reg;

    // multiplier and accumulator
    logic signed [dbtd_pkg::OPA_W-1:0]  op_a;
    logic signed [dbtd_pkg::OPB_W-1:0]  op_b;
    logic signed [dbtd_pkg::PROD_W-1:0] prod_reg, prod_next;
    logic signed [dbtd_pkg::ACC_W-1:0]  acc_reg, acc_next;

    // write-back values
    logic signed [dbtd_pkg::ACC_W-1:0]  flt_rnd, flt_shr;
    logic [dbtd_pkg::Y_W-1:0]           y_sat;
    logic [dbtd_pkg::ACC_W-1:0]         pw_sum, pw_shr;
    logic [dbtd_pkg::PWR_W-1:0]         pw_sat;
    logic                               over;

    // midscale removal and x - x[n-2]
    assign x_val     = dbtd_pkg::X_W'({1'b0, sample}) - dbtd_pkg::X_W'(dbtd_pkg::MIDSCALE);
    assign diff_next = dbtd_pkg::DIFF_W'($signed(x_val))
                     - dbtd_pkg::DIFF_W'($signed(xd2_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            xd1_reg <= '0;
            xd2_reg <= '0;
        end
        else if (load_sample)
        begin
            xd1_reg <= x_val;
            xd2_reg <= xd1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_sample)
        begin
            diff_reg <= diff_next;
        end
    end

    // operand a select
    always_comb
    begin
        case (ctrl.word.a_sel)
            dbtd_pkg::A_TONE_B0: op_a = dbtd_pkg::OPA_W'($signed(coef.tone_b0));
            dbtd_pkg::A_TONE_A1: op_a = dbtd_pkg::OPA_W'($signed(coef.tone_a1));
            dbtd_pkg::A_TONE_A2: op_a = dbtd_pkg::OPA_W'($signed(coef.tone_a2));
            dbtd_pkg::A_REF_B0:  op_a = dbtd_pkg::OPA_W'($signed(coef.ref_b0));
            dbtd_pkg::A_REF_A1:  op_a = dbtd_pkg::OPA_W'($signed(coef.ref_a1));
            dbtd_pkg::A_REF_A2:  op_a = dbtd_pkg::OPA_W'($signed(coef.ref_a2));
            dbtd_pkg::A_THRESH:  op_a = $signed(dbtd_pkg::OPA_W'(coef.threshold_ratio));
            dbtd_pkg::A_DECAY:   op_a = $signed(dbtd_pkg::DECAY_WEIGHT);
            dbtd_pkg::A_GAIN:    op_a = $signed(dbtd_pkg::GAIN_WEIGHT);
            dbtd_pkg::A_TONE_Y:  op_a = dbtd_pkg::OPA_W'($signed(ty1_reg));
            dbtd_pkg::A_REF_Y:   op_a = dbtd_pkg::OPA_W'($signed(ry1_reg));
            default:             op_a = '0;
        endcase
    end

    // operand b select
    always_comb
    begin
        case (ctrl.word.b_sel)
            dbtd_pkg::B_DIFF:    op_b = dbtd_pkg::OPB_W'($signed(diff_reg));
            dbtd_pkg::B_TONE_Y1: op_b = dbtd_pkg::OPB_W'($signed(ty1_reg));
            dbtd_pkg::B_TONE_Y2: op_b = dbtd_pkg::OPB_W'($signed(ty2_reg));
            dbtd_pkg::B_REF_Y1:  op_b = dbtd_pkg::OPB_W'($signed(ry1_reg));
            dbtd_pkg::B_REF_Y2:  op_b = dbtd_pkg::OPB_W'($signed(ry2_reg));
            dbtd_pkg::B_TONE_P:  op_b = $signed(dbtd_pkg::OPB_W'(te_reg));
            dbtd_pkg::B_REF_P:   op_b = $signed(dbtd_pkg::OPB_W'(re_reg));
            dbtd_pkg::B_PROD:    op_b = prod_reg[dbtd_pkg::OPB_W-1:0];
            default:             op_b = '0;
        endcase
    end

    assign prod_next = op_a * op_b;

    // accumulate the product registered in the previous step
    always_comb
    begin
        case (ctrl.word.acc_op)
            dbtd_pkg::ACC_HOLD: acc_next = acc_reg;
            dbtd_pkg::ACC_LOAD: acc_next = prod_reg;
            dbtd_pkg::ACC_ADD:  acc_next = acc_reg + prod_reg;
            dbtd_pkg::ACC_SUB:  acc_next = acc_reg - prod_reg;
            default:            acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step_en)
        begin
            prod_reg <= prod_next;
            acc_reg  <= acc_next;
        end
    end

    // filter output: round half up, floor shift, saturate to 16 bits
    assign flt_rnd = acc_reg + dbtd_pkg::FLT_HALF;
    assign flt_shr = flt_rnd >>> dbtd_pkg::COEF_FRAC_BITS;

    always_comb
    begin
        if (flt_shr > dbtd_pkg::Y_MAX)
        begin
            y_sat = {1'b0, {(dbtd_pkg::Y_W-1){1'b1}}};
        end
        else if (flt_shr < dbtd_pkg::Y_MIN)
        begin
            y_sat = {1'b1, {(dbtd_pkg::Y_W-1){1'b0}}};
        end
        else
        begin
            y_sat = flt_shr[dbtd_pkg::Y_W-1:0];
        end
    end

    // smoothed power: round, drop the weight fraction, saturate
    assign pw_sum = $unsigned(acc_reg) + dbtd_pkg::PWR_HALF;
    assign pw_shr = pw_sum >> dbtd_pkg::PWR_FRAC;
    assign pw_sat = (pw_shr > dbtd_pkg::ACC_W'(dbtd_pkg::PWR_MAX)) ? dbtd_pkg::PWR_MAX
                  : pw_shr[dbtd_pkg::PWR_W-1:0];

    // tone power scaled by 2^16 against ratio times reference power
    assign over = dbtd_pkg::ACC_W'({te_reg, {dbtd_pkg::PWR_FRAC{1'b0}}})
                > $unsigned(prod_reg);

    // write-back of filter state, powers and flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ty1_reg  <= '0;
            ty2_reg  <= '0;
            ry1_reg  <= '0;
            ry2_reg  <= '0;
            te_reg   <= '0;
            re_reg   <= '0;
            flag_reg <= 1'b0;
        end
        else if (ctrl.step_en)
        begin
            case (ctrl.word.dest)
                dbtd_pkg::DST_TONE_Y:
                begin
                    ty1_reg <= y_sat;
                    ty2_reg <= ty1_reg;
                end
                dbtd_pkg::DST_REF_Y:
                begin
                    ry1_reg <= y_sat;
                    ry2_reg <= ry1_reg;
                end
                dbtd_pkg::DST_TONE_P:
                begin
                    te_reg <= pw_sat;
                end
                dbtd_pkg::DST_REF_P:
                begin
                    re_reg <= pw_sat;
                end
                dbtd_pkg::DST_FLAG:
                begin
                    if (over)
                    begin
                        flag_reg <= 1'b1;
                    end
                end
                dbtd_pkg::DST_CLEAR:
                begin
                    flag_reg <= 1'b0;
                end
                default:
                begin
                    flag_reg <= flag_reg;
                end
            endcase
        end
    end

    assign flag        = flag_reg;
    assign tone_energy = te_reg;
    assign ref_energy  = re_reg;

endmodule

// ----- dv/tb_dual_band_tone_detector.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_band_tone_detector
// Self-checking bench for the dual band tone detector. A queue of sample and
// report beats feeds a clocked driver, and a clocked monitor compares every
// output beat with a bit-exact prediction of both biquads, the smoothed band
// powers and the sticky detection flag. Coefficient sets, including the
// saturating extremes and an unmapped register index, are loaded between
// phases while the block is idle. Both sides stall in random bursts.
// ----------------------------------------------------------------------------
module tb_dual_band_tone_detector;

    // prediction constants
    localparam int     MID_CODE     = 1 << (dbtd_pkg::SAMPLE_BITS - 1);
    localparam int     Y_CEIL       = 32767;
    localparam int     Y_FLOOR      = -32768;
    localparam longint DECAY_Q16    = 65470;
    localparam longint GAIN_Q16     = 66;
    localparam longint ROUND_Q16    = 32768;
    localparam longint POWER_CEIL   = (longint'(1) << dbtd_pkg::PWR_W) - 1;

    // run control
    localparam int PHASE_ITEMS    = 218;
    localparam int NUM_PHASES     = 7;
    localparam int SETTLE_CYCLES  = 24;
    localparam int WATCHDOG_LIMIT = 5000;

    localparam logic [dbtd_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam logic [dbtd_pkg::CFG_IDX_W-1:0] REG_LIST [7] = '{dbtd_pkg::REG_TONE_B0,
        dbtd_pkg::REG_TONE_A1, dbtd_pkg::REG_TONE_A2, dbtd_pkg::REG_REF_B0,
        dbtd_pkg::REG_REF_A1, dbtd_pkg::REG_REF_A2, dbtd_pkg::REG_THRESHOLD};

    typedef struct {
        logic                             cmd;
        logic [dbtd_pkg::SAMPLE_BITS-1:0] smp;
    } tone_beat_t;

    typedef struct {
        logic                       detected;
        logic [dbtd_pkg::PWR_W-1:0] tone_power;
        logic [dbtd_pkg::PWR_W-1:0] reference_power;
    } power_report_t;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             in_valid = 1'b0;
    logic                             in_stall;
    logic                             command = dbtd_pkg::CMD_SAMPLE;
    logic [dbtd_pkg::SAMPLE_BITS-1:0] sample = '0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic                             detected;
    logic [dbtd_pkg::PWR_W-1:0]       tone_power;
    logic [dbtd_pkg::PWR_W-1:0]       reference_power;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [dbtd_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
    logic [dbtd_pkg::COEF_W-1:0]      cfg_data = '0;

    // stimulus and expectations
    tone_beat_t    pending_beats[$];
    power_report_t expected_reports[$];
    tone_beat_t    next_beat;
    logic [dbtd_pkg::COEF_W-1:0] coef_plan [7];
    bit            idle_en = 1'b1;
    int            err_count = 0;
    int            send_gap = 0;
    int            hold_cnt = 0;
    int            quiet_cycles = 0;

    // predicted detector state
    logic [dbtd_pkg::COEF_W-1:0] coef_q [8];
    int                          x_d1 = 0;
    int                          x_d2 = 0;
    int                          tone_y1 = 0;
    int                          tone_y2 = 0;
    int                          band_y1 = 0;
    int                          band_y2 = 0;
    logic [dbtd_pkg::PWR_W-1:0]  tone_pwr = '0;
    logic [dbtd_pkg::PWR_W-1:0]  band_pwr = '0;
    logic                        flag_q = 1'b0;

    dual_band_tone_detector dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .command         (command),
        .sample          (sample),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .detected        (detected),
        .tone_power      (tone_power),
        .reference_power (reference_power),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // one biquad output: exact accumulate, round half up, saturate
    function automatic int biquad_out(input logic [dbtd_pkg::COEF_W-1:0] b0,
                                      input logic [dbtd_pkg::COEF_W-1:0] a1,
                                      input logic [dbtd_pkg::COEF_W-1:0] a2, input int diff,
                                      input int y1, input int y2);
        longint acc;
        acc = longint'($signed(b0)) * diff - longint'($signed(a1)) * y1
            - longint'($signed(a2)) * y2;
        acc = (acc + (longint'(1) << (dbtd_pkg::COEF_FRAC_BITS - 1)))
              >>> dbtd_pkg::COEF_FRAC_BITS;
        if (acc > Y_CEIL)
            acc = Y_CEIL;
        else if (acc < Y_FLOOR)
            acc = Y_FLOOR;
        return int'(acc);
    endfunction

    // exponential average of the squared filter output
    function automatic logic [dbtd_pkg::PWR_W-1:0] smooth_power(
        input logic [dbtd_pkg::PWR_W-1:0] p, input int y);
        longint sq;
        longint v;
        sq = longint'(y) * longint'(y);
        v = (DECAY_Q16 * longint'(p) + GAIN_Q16 * sq + ROUND_Q16) >>> 16;
        if (v > POWER_CEIL)
            v = POWER_CEIL;
        return dbtd_pkg::PWR_W'(v);
    endfunction

    // advance the predicted detector by one accepted beat
    task automatic advance_detector(input logic cmd,
                                    input logic [dbtd_pkg::SAMPLE_BITS-1:0] smp);
        power_report_t r;
        int x;
        int diff;
        int yt;
        int yb;
        if (cmd == dbtd_pkg::CMD_REPORT)
        begin
            r.detected = flag_q;
            flag_q = 1'b0;
        end
        else
        begin
            x = int'(smp) - MID_CODE;
            diff = x - x_d2;
            x_d2 = x_d1;
            x_d1 = x;
            yt = biquad_out(coef_q[dbtd_pkg::REG_TONE_B0], coef_q[dbtd_pkg::REG_TONE_A1],
                            coef_q[dbtd_pkg::REG_TONE_A2], diff, tone_y1, tone_y2);
            yb = biquad_out(coef_q[dbtd_pkg::REG_REF_B0], coef_q[dbtd_pkg::REG_REF_A1],
                            coef_q[dbtd_pkg::REG_REF_A2], diff, band_y1, band_y2);
            tone_y2 = tone_y1;
            tone_y1 = yt;
            band_y2 = band_y1;
            band_y1 = yb;
            tone_pwr = smooth_power(tone_pwr, yt);
            band_pwr = smooth_power(band_pwr, yb);
            if ((longint'(tone_pwr) << 16)
                > longint'(coef_q[dbtd_pkg::REG_THRESHOLD]) * longint'(band_pwr))
                flag_q = 1'b1;
            r.detected = flag_q;
        end
        r.tone_power = tone_pwr;
        r.reference_power = band_pwr;
        expected_reports.push_back(r);
    endtask

    // log a failure with the time, the expected and the actual value
    task automatic note_mismatch(input string what, input longint want, input longint got);
        err_count++;
        $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    endtask

    // input driver: holds a stalled beat, otherwise gaps or sends the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && !in_stall)
                advance_detector(command, sample);
            if (in_valid && in_stall)
            begin
                // beat still pending, keep it steady
            end
            else if (send_gap != 0)
            begin
                send_gap <= send_gap - 1;
                in_valid <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                send_gap <= $urandom_range(1, 13) - 1;
                in_valid <= 1'b0;
            end
            else if (pending_beats.size() != 0)
            begin
                next_beat = pending_beats.pop_front();
                in_valid <= 1'b1;
                command <= next_beat.cmd;
                sample <= next_beat.smp;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // output monitor and stall bursts
    always @(posedge clk or negedge rst_n)
    begin
        power_report_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_cnt <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_reports.size() == 0)
                begin
                    note_mismatch("unexpected beat, tone_power", -1, tone_power);
                end
                else
                begin
                    want = expected_reports.pop_front();
                    if (detected !== want.detected)
                        note_mismatch("detected", want.detected, detected);
                    if (tone_power !== want.tone_power)
                        note_mismatch("tone_power", want.tone_power, tone_power);
                    if (reference_power !== want.reference_power)
                        note_mismatch("reference_power", want.reference_power, reference_power);
                end
            end
            if (hold_cnt != 0)
            begin
                hold_cnt <= hold_cnt - 1;
                out_stall <= 1'b1;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                hold_cnt <= $urandom_range(1, 13) - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic queue_beat(input logic cmd, input logic [dbtd_pkg::SAMPLE_BITS-1:0] smp);
        tone_beat_t b;
        b.cmd = cmd;
        b.smp = smp;
        pending_beats.push_back(b);
    endtask

    // square wave around midscale with optional noise, clipped to the adc range
    task automatic queue_tone(input int period, input int amp, input int len, input int noise);
        int v;
        for (int i = 0; i < len; i++)
        begin
            v = MID_CODE + (((i % period) < period / 2) ? amp : -amp);
            if (noise > 0)
                v += int'($urandom_range(0, 2 * noise)) - noise;
            if (v < 0)
                v = 0;
            else if (v > (1 << dbtd_pkg::SAMPLE_BITS) - 1)
                v = (1 << dbtd_pkg::SAMPLE_BITS) - 1;
            queue_beat(dbtd_pkg::CMD_SAMPLE, dbtd_pkg::SAMPLE_BITS'(v));
        end
    endtask

    // mostly tone bursts, some noise runs and reports
    task automatic queue_random_phase(input int count);
        int added;
        int kind;
        int len;
        added = 0;
        while (added < count)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                queue_beat(dbtd_pkg::CMD_REPORT, dbtd_pkg::SAMPLE_BITS'($urandom));
                added++;
            end
            else if (kind <= 2)
            begin
                len = $urandom_range(1, 6);
                repeat (len) queue_beat(dbtd_pkg::CMD_SAMPLE, dbtd_pkg::SAMPLE_BITS'($urandom));
                added += len;
            end
            else
            begin
                len = $urandom_range(6, 40);
                queue_tone($urandom_range(2, 24), $urandom_range(0, MID_CODE), len,
                           $urandom_range(0, 64));
                added += len;
                if ($urandom_range(0, 1) == 1)
                begin
                    queue_beat(dbtd_pkg::CMD_REPORT, dbtd_pkg::SAMPLE_BITS'($urandom));
                    added++;
                end
            end
        end
    endtask

    // wait for every beat to be sent and answered, then let the block go quiet
    task automatic settle();
        do
            @(posedge clk);
        while (pending_beats.size() != 0 || in_valid || expected_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // load coef_plan into all registers, optionally touching the unmapped index
    task automatic program_coefs(input bit poke_unknown);
        int n;
        n = poke_unknown ? 8 : 7;
        for (int i = 0; i < n; i++)
        begin
            cfg_valid <= 1'b1;
            if (i < 7)
            begin
                cfg_index <= REG_LIST[i];
                cfg_data <= coef_plan[i];
            end
            else
            begin
                cfg_index <= REG_UNUSED;
                cfg_data <= dbtd_pkg::COEF_W'($urandom);
            end
            do
                @(posedge clk);
            while (!cfg_ready);
            if (i < 7)
                coef_q[REG_LIST[i]] = coef_plan[i];
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        coef_q[dbtd_pkg::REG_TONE_B0] = dbtd_pkg::RST_TONE_B0;
        coef_q[dbtd_pkg::REG_TONE_A1] = dbtd_pkg::RST_TONE_A1;
        coef_q[dbtd_pkg::REG_TONE_A2] = dbtd_pkg::RST_TONE_A2;
        coef_q[dbtd_pkg::REG_REF_B0] = dbtd_pkg::RST_REF_B0;
        coef_q[dbtd_pkg::REG_REF_A1] = dbtd_pkg::RST_REF_A1;
        coef_q[dbtd_pkg::REG_REF_A2] = dbtd_pkg::RST_REF_A2;
        coef_q[dbtd_pkg::REG_THRESHOLD] = dbtd_pkg::RST_THRESHOLD;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: a report on empty state, adc extremes, a strong in-band tone
        queue_beat(dbtd_pkg::CMD_REPORT, '1);
        queue_beat(dbtd_pkg::CMD_SAMPLE, '0);
        queue_beat(dbtd_pkg::CMD_SAMPLE, '1);
        queue_beat(dbtd_pkg::CMD_SAMPLE, dbtd_pkg::SAMPLE_BITS'(MID_CODE));
        queue_beat(dbtd_pkg::CMD_SAMPLE, '1);
        queue_beat(dbtd_pkg::CMD_SAMPLE, '0);
        queue_beat(dbtd_pkg::CMD_REPORT, '0);
        queue_tone(10, MID_CODE, 12, 0);
        queue_beat(dbtd_pkg::CMD_REPORT, dbtd_pkg::SAMPLE_BITS'(12'hAAA));
        queue_beat(dbtd_pkg::CMD_REPORT, dbtd_pkg::SAMPLE_BITS'(12'h555));
        queue_beat(dbtd_pkg::CMD_SAMPLE, dbtd_pkg::SAMPLE_BITS'(12'hAAA));
        queue_beat(dbtd_pkg::CMD_SAMPLE, dbtd_pkg::SAMPLE_BITS'(12'h555));
        settle();

        for (int phase = 1; phase <= NUM_PHASES; phase++)
        begin
            case (phase)
                1:
                begin
                    foreach (coef_plan[i]) coef_plan[i] = dbtd_pkg::COEF_W'($urandom);
                end
                2:
                begin
                    foreach (coef_plan[i]) coef_plan[i] = 16'h7FFF;
                    coef_plan[6] = 16'hFFFF;
                end
                3:
                begin
                    foreach (coef_plan[i]) coef_plan[i] = 16'h8000;
                    coef_plan[6] = 16'h0000;
                end
                4:
                begin
                    foreach (coef_plan[i]) coef_plan[i] = '0;
                    coef_plan[6] = dbtd_pkg::COEF_W'($urandom);
                end
                5:
                begin
                    coef_plan = '{dbtd_pkg::RST_TONE_B0, dbtd_pkg::RST_TONE_A1,
                                  dbtd_pkg::RST_TONE_A2, dbtd_pkg::RST_REF_B0,
                                  dbtd_pkg::RST_REF_A1, dbtd_pkg::RST_REF_A2,
                                  dbtd_pkg::RST_THRESHOLD};
                end
                default:
                begin
                    // resonant but mostly stable filters with random tuning
                    coef_plan[0] = dbtd_pkg::COEF_W'($urandom_range(0, 4000));
                    coef_plan[1] = dbtd_pkg::COEF_W'(-int'($urandom_range(16000, 32000)));
                    coef_plan[2] = dbtd_pkg::COEF_W'($urandom_range(12000, 16000));
                    coef_plan[3] = dbtd_pkg::COEF_W'($urandom_range(0, 4000));
                    coef_plan[4] = dbtd_pkg::COEF_W'(-int'($urandom_range(16000, 32000)));
                    coef_plan[5] = dbtd_pkg::COEF_W'($urandom_range(12000, 16000));
                    coef_plan[6] = dbtd_pkg::COEF_W'($urandom);
                end
            endcase
            program_coefs(phase == 1 || phase == 4);
            // a stretch without idling mid-run, and none at all in the last phase
            idle_en = (phase != 4) && (phase != NUM_PHASES);
            queue_random_phase(PHASE_ITEMS);
            settle();
        end

        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
